/* design/box_filter_3x3_edge_average_top_macros.svh */
// Assertion macros shared by the box filter checker.
`ifndef BOX_FILTER_3X3_EDGE_AVERAGE_TOP_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AVERAGE_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define BFA_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define BFA_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/bfa_pkg.sv */
// Types, widths and the reciprocal table of the 3x3 box filter.
package bfa_pkg;

    localparam int FRAME_WIDTH_W  = 9;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 13;
    localparam int PIXEL_W        = 8;
    localparam int ROW_W          = 12;
    localparam int COL_OUT_W      = 8;
    localparam int LINE_W         = 14;
    localparam int SUM_W          = 12;
    localparam int RECIP_W        = 16;
    localparam int RECIP_SHIFT    = 15;
    localparam int PROD_W         = SUM_W + RECIP_W;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [PIXEL_W-1:0] pixel;
    } pix_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]   smoothed;
        logic [ROW_W-1:0]     out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 frame_end;
    } pix_out_t;

    typedef struct packed {
        logic                 emit;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
        logic                 left_ok;
        logic                 right_ok;
        logic                 top_ok;
        logic                 bottom_ok;
    } bfa_pos_t;

    // floor(sum / count) == (sum * recip) >> RECIP_SHIFT for every reachable sum
    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] ncol,
                                                    input logic [1:0] nrow);
        logic [3:0] cnt;
        cnt = {2'b00, ncol} * {2'b00, nrow};
        case (cnt)
            4'd1:    recip_of = 16'd32768;
            4'd2:    recip_of = 16'd16384;
            4'd3:    recip_of = 16'd10923;
            4'd4:    recip_of = 16'd8192;
            4'd6:    recip_of = 16'd5462;
            4'd9:    recip_of = 16'd3641;
            default: recip_of = 16'd0;
        endcase
    endfunction

endpackage

/* design/bfa_stream_if.sv */
// Valid/ready stream channel carrying one payload per transfer.
interface bfa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/box_filter_3x3_edge_average_top.sv */
// 3x3 edge-aware box filter over a raster pixel stream, line buffer in one RAM.
// Throughput: one transfer per cycle whenever results are taken; a stalled result stops input.
// A result's window completes with the transfer frame_width + 1 transfers after its own pixel;
// the result then passes the s1, s2, s3 and s4 registers to the output register. Drain transfers flush the tail.
// Reset: positions to zero, frame size 256 x 256; the line RAM is not cleared.
module box_filter_3x3_edge_average_top
    import bfa_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bfa_stream_if.sink             pixels,
    bfa_stream_if.source           results
);

    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_REG_MAX = (1 << FRAME_WIDTH_W) - 1;
    localparam int H_REG_MAX = (1 << FRAME_HEIGHT_W) - 1;
    localparam int W_CAP     = (MAX_WIDTH > W_REG_MAX) ? W_REG_MAX : MAX_WIDTH;
    localparam int H_CAP     = (MAX_HEIGHT > H_REG_MAX) ? H_REG_MAX : MAX_HEIGHT;
    localparam logic [FRAME_WIDTH_W-1:0]  W_CAP_V = FRAME_WIDTH_W'(W_CAP);
    localparam logic [FRAME_HEIGHT_W-1:0] H_CAP_V = FRAME_HEIGHT_W'(H_CAP);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg, frame_width_next;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg, frame_height_next;
    logic [FRAME_WIDTH_W-1:0]  in_col_reg, in_col_next;
    logic [LINE_W-1:0]         in_line_reg, in_line_next;
    logic [FRAME_WIDTH_W-1:0]  emit_col_reg, emit_col_next;
    logic [LINE_W-1:0]         emit_line_reg, emit_line_next;

    logic [FRAME_WIDTH_W-1:0]  w_eff;
    logic [FRAME_HEIGHT_W-1:0] h_eff;
    logic                      adv;
    logic                      proceed;
    logic                      active;
    logic                      emit0;
    logic                      col_end;
    logic                      ecol_end;
    logic                      eline_end;
    logic                      last0;
    logic [PIXEL_W-1:0]        pix0;
    logic [ADDR_W-1:0]         rd_addr;
    bfa_pos_t                  pos0;

    logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] rd_word_reg;
    logic [2*PIXEL_W-1:0] s1_word;
    logic [2*PIXEL_W-1:0] wr_word;
    logic                 mem_wr;
    logic                 fwd_valid_reg;
    logic [2*PIXEL_W-1:0] fwd_word_reg;

    logic               s1_valid_reg;
    bfa_pos_t           s1_pos_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;

    logic [PIXEL_W-1:0] window_reg [9];

    logic     s2_valid_reg;
    bfa_pos_t s2_pos_reg;

    logic [SUM_W-2:0]   col_sum [3];
    logic [2:0]         col_ok;
    logic [2:0]         row_ok;
    logic [SUM_W-1:0]   sum_total;
    logic [1:0]         ncol;
    logic [1:0]         nrow;

    logic               s3_valid_reg;
    bfa_pos_t           s3_pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [RECIP_W-1:0] recip_reg;

    logic              s4_valid_reg;
    bfa_pos_t          s4_pos_reg;
    logic [PROD_W-1:0] prod_reg;

    logic     out_valid_reg;
    pix_out_t out_data_reg;

    // Frame size and input position
    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = FRAME_WIDTH_W'(1);
        else if (frame_width_reg > W_CAP_V)
            w_eff = W_CAP_V;
        else
            w_eff = frame_width_reg;

        if (frame_height_reg == '0)
            h_eff = FRAME_HEIGHT_W'(1);
        else if (frame_height_reg > H_CAP_V)
            h_eff = H_CAP_V;
        else
            h_eff = frame_height_reg;
    end

    assign adv           = !out_valid_reg || results.ready;
    assign pixels.ready  = adv;
    assign active        = in_line_reg < {1'b0, h_eff};
    assign proceed       = pixels.valid && adv && !(active && (pixels.data.mode == MODE_DRAIN));
    assign pix0          = active ? pixels.data.pixel : '0;
    assign rd_addr       = ADDR_W'(in_col_reg);
    assign emit0         = (in_line_reg >= LINE_W'(2))
                           || ((in_line_reg == LINE_W'(1)) && (in_col_reg != '0));
    assign col_end       = ({1'b0, in_col_reg} + 10'd1) >= {1'b0, w_eff};
    assign ecol_end      = ({1'b0, emit_col_reg} + 10'd1) >= {1'b0, w_eff};
    assign eline_end     = (emit_line_reg + LINE_W'(1)) >= {1'b0, h_eff};
    assign last0         = eline_end && ecol_end;

    always_comb
    begin
        pos0.emit      = emit0;
        pos0.row       = emit_line_reg[ROW_W-1:0];
        pos0.col       = emit_col_reg[COL_OUT_W-1:0];
        pos0.last      = last0;
        pos0.left_ok   = emit_col_reg != '0;
        pos0.right_ok  = !ecol_end;
        pos0.top_ok    = emit_line_reg != '0;
        pos0.bottom_ok = !eline_end;
    end

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_col_next       = in_col_reg;
        in_line_next      = in_line_reg;
        emit_col_next     = emit_col_reg;
        emit_line_next    = emit_line_reg;
        if (cfg_wr_en)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                frame_width_next = cfg_data[FRAME_WIDTH_W-1:0];
            else if (cfg_index == REG_FRAME_HEIGHT)
                frame_height_next = cfg_data[FRAME_HEIGHT_W-1:0];
            in_col_next    = '0;
            in_line_next   = '0;
            emit_col_next  = '0;
            emit_line_next = '0;
        end
        else if (proceed)
        begin
            if (col_end)
            begin
                in_col_next  = '0;
                in_line_next = in_line_reg + LINE_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + FRAME_WIDTH_W'(1);
            end
            if (emit0)
            begin
                if (last0)
                begin
                    in_col_next    = '0;
                    in_line_next   = '0;
                    emit_col_next  = '0;
                    emit_line_next = '0;
                end
                else if (ecol_end)
                begin
                    emit_col_next  = '0;
                    emit_line_next = emit_line_reg + LINE_W'(1);
                end
                else
                begin
                    emit_col_next = emit_col_reg + FRAME_WIDTH_W'(1);
                end
            end
        end
    end

    // Line RAM: read at transfer, write back from the s1 registers when the pipeline advances
    assign s1_word = fwd_valid_reg ? fwd_word_reg : rd_word_reg;
    assign wr_word = {s1_word[PIXEL_W-1:0], s1_pix_reg};
    assign mem_wr  = adv && s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            line_mem[s1_addr_reg] <= wr_word;
    end

    always_ff @(posedge clk)
    begin
        if (proceed)
            rd_word_reg <= line_mem[rd_addr];
    end

    // Column sums over the in-frame rows, then the in-frame columns
    assign col_ok = {s2_pos_reg.right_ok, 1'b1, s2_pos_reg.left_ok};
    assign row_ok = {s2_pos_reg.bottom_ok, 1'b1, s2_pos_reg.top_ok};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            col_sum[c] = (row_ok[0] ? {3'b000, window_reg[c*3]} : '0)
                         + {3'b000, window_reg[c*3+1]}
                         + (row_ok[2] ? {3'b000, window_reg[c*3+2]} : '0);
        end
        sum_total = (col_ok[0] ? {1'b0, col_sum[0]} : '0)
                    + {1'b0, col_sum[1]}
                    + (col_ok[2] ? {1'b0, col_sum[2]} : '0);
        ncol = 2'd1 + {1'b0, col_ok[0]} + {1'b0, col_ok[2]};
        nrow = 2'd1 + {1'b0, row_ok[0]} + {1'b0, row_ok[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_W'(256);
            frame_height_reg <= FRAME_HEIGHT_W'(256);
            in_col_reg       <= '0;
            in_line_reg      <= '0;
            emit_col_reg     <= '0;
            emit_line_reg    <= '0;
            fwd_valid_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 9; i++)
                window_reg[i] <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_line_reg      <= in_line_next;
            emit_col_reg     <= emit_col_next;
            emit_line_reg    <= emit_line_next;
            if (proceed)
                fwd_valid_reg <= s1_valid_reg && (s1_addr_reg == rd_addr);
            if (mem_wr)
            begin
                for (int i = 0; i < 6; i++)
                    window_reg[i] <= window_reg[i+3];
                window_reg[6] <= s1_word[2*PIXEL_W-1:PIXEL_W];
                window_reg[7] <= s1_word[PIXEL_W-1:0];
                window_reg[8] <= s1_pix_reg;
            end
            if (adv)
            begin
                s1_valid_reg  <= proceed;
                s2_valid_reg  <= s1_valid_reg && s1_pos_reg.emit;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed)
        begin
            fwd_word_reg <= wr_word;
            s1_pos_reg   <= pos0;
            s1_pix_reg   <= pix0;
            s1_addr_reg  <= rd_addr;
        end
        if (adv)
        begin
            s2_pos_reg             <= s1_pos_reg;
            s3_pos_reg             <= s2_pos_reg;
            sum_reg                <= sum_total;
            recip_reg              <= recip_of(ncol, nrow);
            s4_pos_reg             <= s3_pos_reg;
            prod_reg               <= PROD_W'(sum_reg) * PROD_W'(recip_reg);
            out_data_reg.smoothed  <= prod_reg[RECIP_SHIFT +: PIXEL_W];
            out_data_reg.out_row   <= s4_pos_reg.row;
            out_data_reg.out_col   <= s4_pos_reg.col;
            out_data_reg.frame_end <= s4_pos_reg.last;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

/* design/bfa_checker.sv */
// Port-level checker for the box filter, bound to the top level.
`include "box_filter_3x3_edge_average_top_macros.svh"

module bfa_checker
    import bfa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     cfg_wr_en,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input pix_out_t out_data
);

    logic                 origin_reg, origin_next;
    logic [COL_OUT_W-1:0] prev_col_reg, prev_col_next;
    logic                 out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        origin_next   = origin_reg;
        prev_col_next = prev_col_reg;
        if (cfg_wr_en)
            origin_next = 1'b1;
        else if (out_xfer)
            origin_next = out_data.frame_end;
        if (out_xfer)
            prev_col_next = out_data.out_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg   <= 1'b1;
            prev_col_reg <= '0;
        end
        else
        begin
            origin_reg   <= origin_next;
            prev_col_reg <= prev_col_next;
        end
    end

    `BFA_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && !out_ready,
        out_valid && $stable(out_data),
        "stalled result changed")
    `BFA_ASSERT_SAME(a_in_blocked, clk, rst_n,
        in_valid && out_valid && !out_ready,
        !in_ready,
        "input taken while result stalled")
    `BFA_ASSERT_SAME(a_frame_origin, clk, rst_n,
        out_valid && origin_reg,
        (out_data.out_row == '0) && (out_data.out_col == '0),
        "frame does not start at origin")
    `BFA_ASSERT_SAME(a_col_step, clk, rst_n,
        out_valid && !origin_reg,
        (out_data.out_col == COL_OUT_W'(prev_col_reg + 1'b1)) || (out_data.out_col == '0),
        "column skipped")

endmodule

bind box_filter_3x3_edge_average_top bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
);
